FILE: rtl/cct_pkg.sv
// cct_pkg: shared types, constants and calendar helpers for the clock calendar
// depends on nothing; imported by cct_calc, clock_calendar_tick and cct_checker
package cct_pkg;

   // last legal value of each wrapping counter
   localparam logic [5:0] SecLast   = 6'd59;
   localparam logic [5:0] MinLast   = 6'd59;
   localparam logic [4:0] HourLast  = 5'd23;
   localparam logic [3:0] MonthLast = 4'd12;
   localparam logic [3:0] MonthFirst = 4'd1;
   localparam logic [4:0] DayFirst  = 5'd1;

   // divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare
   localparam logic [15:0] Inv25    = 16'h5C29;
   localparam logic [15:0] Div25Max = 16'd2621;

   localparam logic FuncTick = 1'b0;
   localparam logic FuncSet  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HOUR   = 3'd1,
      ST_BAD_MINUTE = 3'd2,
      ST_BAD_SECOND = 3'd3,
      ST_BAD_MONTH  = 3'd4,
      ST_BAD_DAY    = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_type;

   typedef struct packed {
      logic        func;
      logic [3:0]  set_month;
      logic [4:0]  set_day;
      logic [15:0] set_year;
      logic [4:0]  set_hour;
      logic [5:0]  set_minute;
      logic [5:0]  set_second;
   } req_type;

   localparam cal_type CalReset = '{
      year:   16'd2000,
      month:  4'd1,
      day:    5'd1,
      hour:   5'd0,
      minute: 6'd0,
      second: 6'd0
   };

   // divisible by 400, or by 4 and not by 100
   function automatic logic is_leap(input logic [15:0] y);
      logic [31:0] prod;
      logic        div25;
      prod  = y * Inv25;
      div25 = (prod[15:0] <= Div25Max);
      return ((y[3:0] == 4'd0) && div25) || ((y[1:0] == 2'd0) && !div25);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/clock_calendar_tick.sv
// clock_calendar_tick: real-time clock with a Gregorian calendar, top level
// depends on cct_pkg and cct_calc
//
// Usage
//   req_ channel: one beat is either a one-second tick (req_func = 0) or a
//   set command (req_func = 1) carrying month, day, year, hour, minute and
//   second. A set is checked hour, minute, second, month, day; if all pass
//   the fields are loaded, otherwise the time is kept and rsp_status names
//   the first bad field.
//   rsp_ channel: exactly one beat per request, showing the clock after that
//   request and its status (always ok for a tick).
//   Requests pass the input register, then the state/response register.
//   Throughput: one request per cycle while rsp_ready is high; the whole
//   update is one pass through the carry chain and two 16-bit leap checks
//   (a multiply by the inverse of 25 each) between the input register and
//   the state/response register.
//   Reset: synchronous, clears both valid flags and loads 00:00:00 on
//   1 January 2000.
//   Stall: while rsp_ready is low the response holds; one further request
//   waits in the input register, then req_ready drops.
module clock_calendar_tick (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [3:0]  req_set_month,
   input  logic [4:0]  req_set_day,
   input  logic [15:0] req_set_year,
   input  logic [4:0]  req_set_hour,
   input  logic [5:0]  req_set_minute,
   input  logic [5:0]  req_set_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic [15:0] rsp_cur_year,
   output logic [4:0]  rsp_cur_hour,
   output logic [5:0]  rsp_cur_minute,
   output logic [5:0]  rsp_cur_second,
   output logic [2:0]  rsp_status
);
   import cct_pkg::*;

   req_type    req_ff,       req_in;
   logic       req_vld_ff,   req_vld_in;
   cal_type    cal_ff,       cal_in;
   status_type status_ff,    status_in;
   logic       rsp_vld_ff,   rsp_vld_in;
   cal_type    calc_nxt;
   status_type calc_status;
   logic       req_take;
   logic       step;

   assign step      = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || step;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_in = req_take ? req_type'{
         func:       req_func,
         set_month:  req_set_month,
         set_day:    req_set_day,
         set_year:   req_set_year,
         set_hour:   req_set_hour,
         set_minute: req_set_minute,
         set_second: req_set_second
      } : req_ff;
      req_vld_in = req_take ? 1'b1 : (step ? 1'b0 : req_vld_ff);
      cal_in     = step ? calc_nxt : cal_ff;
      status_in  = step ? calc_status : status_ff;
      rsp_vld_in = step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   end

   cct_calc u_calc (
      .cur    (cal_ff),
      .req    (req_ff),
      .nxt    (calc_nxt),
      .status (calc_status)
   );

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cal_ff     <= CalReset;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         cal_ff     <= cal_in;
      end
   end

   // the response beat shows the state left by the last step
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_cur_month  = cal_ff.month;
   assign rsp_cur_day    = cal_ff.day;
   assign rsp_cur_year   = cal_ff.year;
   assign rsp_cur_hour   = cal_ff.hour;
   assign rsp_cur_minute = cal_ff.minute;
   assign rsp_cur_second = cal_ff.second;
   assign rsp_status     = status_ff;

endmodule

FILE: rtl/cct_calc.sv
// cct_calc: next calendar state and status for one tick or set beat
// depends on cct_pkg (types, leap rule, month lengths)
module cct_calc (
   input  cct_pkg::cal_type    cur,
   input  cct_pkg::req_type    req,
   output cct_pkg::cal_type    nxt,
   output cct_pkg::status_type status
);
   import cct_pkg::*;

   cal_type    tick_cal;
   logic       sec_wrap;
   logic       min_wrap;
   logic       hour_wrap;
   logic       day_wrap;
   logic       month_wrap;
   logic [4:0] cur_len;
   logic [4:0] set_len;
   status_type chk;

   // tick: cascaded carries from seconds up to the year
   always_comb begin
      cur_len    = days_in(cur.month, is_leap(cur.year));
      sec_wrap   = (cur.second >= SecLast);
      min_wrap   = (cur.minute >= MinLast);
      hour_wrap  = (cur.hour >= HourLast);
      day_wrap   = (cur.day >= cur_len);
      month_wrap = (cur.month >= MonthLast);

      tick_cal = cur;
      tick_cal.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
      if (sec_wrap) begin
         tick_cal.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
         if (min_wrap) begin
            tick_cal.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
            if (hour_wrap) begin
               if (day_wrap) begin
                  tick_cal.day = DayFirst;
                  if (month_wrap) begin
                     tick_cal.month = MonthFirst;
                     tick_cal.year  = cur.year + 16'd1;
                  end else begin
                     tick_cal.month = cur.month + 4'd1;
                  end
               end else begin
                  tick_cal.day = cur.day + 5'd1;
               end
            end
         end
      end
   end

   // set: first failing check wins
   always_comb begin
      set_len = days_in(req.set_month, is_leap(req.set_year));
      if (req.set_hour > HourLast) begin
         chk = ST_BAD_HOUR;
      end else if (req.set_minute > MinLast) begin
         chk = ST_BAD_MINUTE;
      end else if (req.set_second > SecLast) begin
         chk = ST_BAD_SECOND;
      end else if (req.set_month < MonthFirst || req.set_month > MonthLast) begin
         chk = ST_BAD_MONTH;
      end else if (req.set_day < DayFirst || req.set_day > set_len) begin
         chk = ST_BAD_DAY;
      end else begin
         chk = ST_OK;
      end
   end

   always_comb begin
      if (req.func == FuncTick) begin
         nxt    = tick_cal;
         status = ST_OK;
      end else begin
         status = chk;
         if (chk == ST_OK) begin
            nxt = '{
               year:   req.set_year,
               month:  req.set_month,
               day:    req.set_day,
               hour:   req.set_hour,
               minute: req.set_minute,
               second: req.set_second
            };
         end else begin
            nxt = cur;
         end
      end
   end

endmodule

FILE: rtl/cct_checker.sv
// cct_checker: port-level checks on clock_calendar_tick, bound to the top level
// depends on cct_pkg and clock_calendar_tick
module cct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_cur_month,
   input logic [4:0]  rsp_cur_day,
   input logic [15:0] rsp_cur_year,
   input logic [4:0]  rsp_cur_hour,
   input logic [5:0]  rsp_cur_minute,
   input logic [5:0]  rsp_cur_second,
   input logic [2:0]  rsp_status
);
   import cct_pkg::*;

   // no response beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // every shown time is a legal clock value
   a_time_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cur_second <= SecLast) && (rsp_cur_minute <= MinLast) &&
                    (rsp_cur_hour <= HourLast) && (rsp_cur_month >= MonthFirst) &&
                    (rsp_cur_month <= MonthLast) && (rsp_cur_day >= DayFirst))
      else $error("response shows an out-of-range time");

   // the day never exceeds the length of the shown month
   a_day_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_day <= days_in(rsp_cur_month, is_leap(rsp_cur_year)))
      else $error("response day beyond month length");

   // a stalled response beat stays valid and holds its status, second, day and year
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_cur_second) && $stable(rsp_cur_day) && $stable(rsp_cur_year))
      else $error("stalled response changed");

   // a request can only wait on a full input stage, so ready stays up when idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid |=> req_ready)
      else $error("input not ready with the block drained");

endmodule

bind clock_calendar_tick cct_checker u_cct_checker (.*);

FILE: tb/tb.sv
// tb: self-checking bench for clock_calendar_tick, directed calendar cases then random beats
// depends on cct_pkg and the clock_calendar_tick rtl; keeps its own calendar model
module tb;
   import cct_pkg::*;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned ReportMax   = 10;

   typedef struct packed {
      cal_type    cal;
      status_type status;
   } readout_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FuncTick;
   logic [3:0]  req_set_month = '0;
   logic [4:0]  req_set_day = '0;
   logic [15:0] req_set_year = '0;
   logic [4:0]  req_set_hour = '0;
   logic [5:0]  req_set_minute = '0;
   logic [5:0]  req_set_second = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_cur_month;
   logic [4:0]  rsp_cur_day;
   logic [15:0] rsp_cur_year;
   logic [4:0]  rsp_cur_hour;
   logic [5:0]  rsp_cur_minute;
   logic [5:0]  rsp_cur_second;
   logic [2:0]  rsp_status;

   cal_type          clock_now;
   readout_type      pending_readouts[$];
   int unsigned      mismatches = 0;
   int unsigned      cycles = 0;
   int unsigned      idle_odds = 0;   // 0 means no idling on either side

   clock_calendar_tick u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- calendar model

   function automatic bit leap_year(input logic [15:0] y);
      int unsigned v;
      v = {16'd0, y};
      return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
      if (m == 4'd2)
         return leap_year(y) ? 5'd29 : 5'd28;
      if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
         return 5'd30;
      if (m >= 4'd1 && m <= 4'd12)
         return 5'd31;
      return 5'd0;
   endfunction

   // applies one accepted beat to the model clock and returns the readout it should give
   function automatic readout_type predict_beat(input req_type r);
      readout_type res;
      res.status = ST_OK;
      if (r.func == FuncTick) begin
         if (clock_now.second < SecLast) begin
            clock_now.second++;
         end else begin
            clock_now.second = '0;
            if (clock_now.minute < MinLast) begin
               clock_now.minute++;
            end else begin
               clock_now.minute = '0;
               if (clock_now.hour < HourLast) begin
                  clock_now.hour++;
               end else begin
                  clock_now.hour = '0;
                  if (clock_now.day < month_length(clock_now.month, clock_now.year)) begin
                     clock_now.day++;
                  end else begin
                     clock_now.day = 5'd1;
                     if (clock_now.month < 4'd12) begin
                        clock_now.month++;
                     end else begin
                        clock_now.month = 4'd1;
                        clock_now.year  = clock_now.year + 16'd1;
                     end
                  end
               end
            end
         end
      end else begin
         if (r.set_hour > 5'd23)
            res.status = ST_BAD_HOUR;
         else if (r.set_minute > 6'd59)
            res.status = ST_BAD_MINUTE;
         else if (r.set_second > 6'd59)
            res.status = ST_BAD_SECOND;
         else if (r.set_month < 4'd1 || r.set_month > 4'd12)
            res.status = ST_BAD_MONTH;
         else if (r.set_day < 5'd1 || r.set_day > month_length(r.set_month, r.set_year))
            res.status = ST_BAD_DAY;
         if (res.status == ST_OK) begin
            clock_now.year   = r.set_year;
            clock_now.month  = r.set_month;
            clock_now.day    = r.set_day;
            clock_now.hour   = r.set_hour;
            clock_now.minute = r.set_minute;
            clock_now.second = r.set_second;
         end
      end
      res.cal = clock_now;
      return res;
   endfunction

   // ---------------------------------------------------------------- beat builders

   function automatic req_type tick_cmd();
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom}));   // ignored fields get noise
      r.func = FuncTick;
      return r;
   endfunction

   function automatic req_type set_cmd(input logic [3:0] m, input logic [4:0] d,
                                       input logic [15:0] y, input logic [4:0] h,
                                       input logic [5:0] mi, input logic [5:0] s);
      req_type r;
      r.func       = FuncSet;
      r.set_month  = m;
      r.set_day    = d;
      r.set_year   = y;
      r.set_hour   = h;
      r.set_minute = mi;
      r.set_second = s;
      return r;
   endfunction

   function automatic logic [15:0] pick_year();
      case ($urandom_range(4))
         0:       return 16'($urandom_range(163) * 400);
         1:       return 16'($urandom_range(655) * 100);
         2:       return 16'hFFFF - 16'($urandom_range(2));
         3:       return 16'($urandom_range(16383) * 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // half ticks; the rest are sets near a rollover, legal random sets and noise
   function automatic req_type random_item();
      int unsigned   kind;
      logic [3:0]    m;
      logic [15:0]   y;
      logic [4:0]    d;
      kind = $urandom_range(99);
      m    = 4'($urandom_range(12, 1));
      y    = pick_year();
      d    = month_length(m, y);
      if (kind < 50)
         return tick_cmd();
      if (kind < 72)
         return set_cmd(m, d - 5'($urandom_range(1)), y, 5'd23, 6'd59,
                        6'($urandom_range(59, 56)));
      if (kind < 85)
         return set_cmd(m, 5'($urandom_range(d, 1)), y, 5'($urandom_range(23)),
                        6'($urandom_range(59)), 6'($urandom_range(59)));
      return set_cmd(4'($urandom), 5'($urandom), 16'($urandom), 5'($urandom),
                     6'($urandom), 6'($urandom));
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_beat(input req_type r);
      int unsigned gap;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
         gap = $urandom_range(7, 1);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_func       = r.func;
      req_set_month  = r.set_month;
      req_set_day    = r.set_day;
      req_set_year   = r.set_year;
      req_set_hour   = r.set_hour;
      req_set_minute = r.set_minute;
      req_set_second = r.set_second;
      do @(posedge clock); while (!req_ready);
      pending_readouts.push_back(predict_beat(r));
   endtask

   initial begin : readout_stall
      int unsigned hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
            rsp_ready = 1'b0;
            hold = $urandom_range(6);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= ReportMax)
            $display("tb: %s mismatch, expected %0d got %0d at cycle %0d",
                     name, want, got, cycles);
      end
   endtask

   always @(posedge clock) begin : readout_check
      readout_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_readouts.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportMax)
               $display("tb: readout beat with nothing pending at cycle %0d", cycles);
         end else begin
            want = pending_readouts.pop_front();
            check_field("month",  16'(want.cal.month),  16'(rsp_cur_month));
            check_field("day",    16'(want.cal.day),    16'(rsp_cur_day));
            check_field("year",   want.cal.year,        rsp_cur_year);
            check_field("hour",   16'(want.cal.hour),   16'(rsp_cur_hour));
            check_field("minute", 16'(want.cal.minute), 16'(rsp_cur_minute));
            check_field("second", 16'(want.cal.second), 16'(rsp_cur_second));
            check_field("status", 16'(want.status),     16'(rsp_status));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_value();
      send_beat(tick_cmd());
      send_beat(tick_cmd());
   endtask

   task automatic test_set_checks();
      send_beat(set_cmd(4'd1, 5'd1, 16'd2000, 5'd24, 6'd0, 6'd0));
      // every field bad: hour wins
      send_beat(set_cmd(4'd15, 5'd0, 16'd2000, 5'd31, 6'd63, 6'd63));
      send_beat(set_cmd(4'd1, 5'd1, 16'd2000, 5'd23, 6'd60, 6'd0));
      send_beat(set_cmd(4'd0, 5'd0, 16'd2000, 5'd0, 6'd63, 6'd63));
      send_beat(set_cmd(4'd1, 5'd1, 16'd2000, 5'd0, 6'd0, 6'd60));
      send_beat(set_cmd(4'd0, 5'd0, 16'd2000, 5'd0, 6'd0, 6'd63));
      send_beat(set_cmd(4'd0, 5'd0, 16'd2000, 5'd0, 6'd0, 6'd0));
      send_beat(set_cmd(4'd13, 5'd1, 16'd2000, 5'd0, 6'd0, 6'd0));
      send_beat(set_cmd(4'd1, 5'd0, 16'd2000, 5'd0, 6'd0, 6'd0));
      send_beat(set_cmd(4'd4, 5'd31, 16'd2000, 5'd0, 6'd0, 6'd0));
      // century year not divisible by 400 has no leap day
      send_beat(set_cmd(4'd2, 5'd29, 16'd1900, 5'd0, 6'd0, 6'd0));
      send_beat(set_cmd(4'd2, 5'd30, 16'd2000, 5'd0, 6'd0, 6'd0));
      send_beat(set_cmd(4'd2, 5'd29, 16'd0, 5'd12, 6'd30, 6'd30));
      // top of every field, then wrap of the year
      send_beat(set_cmd(4'd12, 5'd31, 16'hFFFF, 5'd23, 6'd59, 6'd59));
      send_beat(tick_cmd());
   endtask

   task automatic test_rollovers();
      send_beat(set_cmd(4'd2, 5'd28, 16'd2100, 5'd23, 6'd59, 6'd59));
      send_beat(tick_cmd());
      send_beat(set_cmd(4'd2, 5'd28, 16'd2024, 5'd23, 6'd59, 6'd59));
      send_beat(tick_cmd());
      send_beat(set_cmd(4'd2, 5'd29, 16'd2024, 5'd23, 6'd59, 6'd59));
      send_beat(tick_cmd());
      send_beat(set_cmd(4'd4, 5'd30, 16'd2023, 5'd10, 6'd0, 6'd59));
      send_beat(tick_cmd());
   endtask

   task automatic test_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0)
            case ($urandom_range(2))
               0:       idle_odds = 0;
               1:       idle_odds = 3;
               default: idle_odds = 8;
            endcase
         send_beat(random_item());
      end
   endtask

   task automatic test_steady(input int unsigned count);
      idle_odds = 0;
      for (int unsigned i = 0; i < count; i++)
         send_beat(random_item());
   endtask

   initial begin
      clock_now = '{year: 16'd2000, month: 4'd1, day: 5'd1,
                    hour: 5'd0, minute: 6'd0, second: 6'd0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_odds = 4;
      test_reset_value();
      test_set_checks();
      test_rollovers();
      test_random(340);
      test_steady(40);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readouts.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: clock_calendar_tick.f
rtl/cct_pkg.sv
rtl/cct_calc.sv
rtl/clock_calendar_tick.sv
rtl/cct_checker.sv
tb/tb.sv
